// ===== rtl/crc16mc_pkg.sv =====
`default_nettype none

package crc16mc_pkg;

  localparam logic [2:0] MODE_REFL_NOXOR  = 3'd0;
  localparam logic [2:0] MODE_X25         = 3'd1;
  localparam logic [2:0] MODE_CCITT_FALSE = 3'd2;
  localparam logic [2:0] MODE_XMODEM      = 3'd3;
  localparam logic [2:0] MODE_MODBUS      = 3'd4;

  localparam logic [15:0] POLY_REFL_CCITT = 16'h8408;
  localparam logic [15:0] POLY_REFL_MODBUS = 16'hA001;
  localparam logic [15:0] POLY_NORMAL     = 16'h1021;
  localparam logic [15:0] CRC_ONES        = 16'hFFFF;
  localparam logic [15:0] CRC_ZERO        = 16'h0000;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] stored_crc;
  } in_t;

  typedef struct packed {
    logic [15:0] crc_value;
    logic        crc_match;
  } out_t;

  // undefined codes fall back to the reflected no-xor variant
  function automatic logic [2:0] eff_mode(input logic [2:0] m);
    logic [2:0] r;
    r = (m > MODE_MODBUS) ? MODE_REFL_NOXOR : m;
    return r;
  endfunction

  function automatic logic [15:0] mode_init(input logic [2:0] m);
    logic [15:0] r;
    r = (m == MODE_XMODEM) ? CRC_ZERO : CRC_ONES;
    return r;
  endfunction

  function automatic logic [15:0] mode_xorout(input logic [2:0] m);
    logic [15:0] r;
    r = (m == MODE_X25) ? CRC_ONES : CRC_ZERO;
    return r;
  endfunction

  // one byte folded into the crc, eight bit steps unrolled into xor logic
  function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                           input logic [7:0]  b,
                                           input logic [2:0]  m);
    logic [15:0] c;
    logic [15:0] poly;
    logic        normal;
    normal = (m == MODE_CCITT_FALSE) || (m == MODE_XMODEM);
    poly   = (m == MODE_MODBUS) ? POLY_REFL_MODBUS : POLY_REFL_CCITT;
    if (normal) begin
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ POLY_NORMAL) : {c[14:0], 1'b0};
      end
    end else begin
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ({1'b0, c[15:1]} ^ poly) : {1'b0, c[15:1]};
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] bit_rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[15 - i] = v[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/crc16_multimode_check.sv =====
// a result is registered and appears in the cycle after its last byte is accepted
// throughput: one byte per cycle; the byte fold is a single unrolled xor network
// on the running crc register, so a new transaction is taken every cycle
// input stalls only in cycles where a held result waits with out_ready low
// reset (rst_n low, synchronous): mode 0, running crc 0xffff, no result pending
// a mode write reloads the running crc with the new mode's initial value
`default_nettype none

module crc16_multimode_check
  import crc16mc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_t            out_data,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_wr_data
);

  logic [2:0]  mode_r;
  logic [15:0] running_crc_r;
  logic [15:0] running_crc_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_t        out_data_r;
  out_t        out_data_nxt;

  logic [2:0]  mode_eff;
  logic [15:0] folded;
  logic [15:0] fin;
  logic        match;
  logic        in_acc;

  assign mode_eff = eff_mode(mode_r);
  // output register frees up when the pending result is taken
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign folded = crc_fold(running_crc_r, in_data.data_byte, mode_eff);
  assign fin    = folded ^ mode_xorout(mode_eff);
  assign match  = (fin == in_data.stored_crc) ||
                  (fin == {in_data.stored_crc[7:0], in_data.stored_crc[15:8]}) ||
                  (bit_rev16(fin) == in_data.stored_crc);

  always_comb begin
    running_crc_nxt = running_crc_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    if (cfg_wr_en) begin
      running_crc_nxt = mode_init(eff_mode(cfg_wr_data));
    end else if (in_acc) begin
      if (in_data.last_byte) begin
        running_crc_nxt        = mode_init(mode_eff);
        out_valid_nxt          = 1'b1;
        out_data_nxt.crc_value = fin;
        out_data_nxt.crc_match = match;
      end else begin
        running_crc_nxt = folded;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_REFL_NOXOR;
      running_crc_r <= CRC_ONES;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      running_crc_r <= running_crc_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result pending after reset");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.last_byte && !cfg_wr_en |=> out_valid_r)
    else $error("last byte accepted without a result");

  a_last_reloads_crc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.last_byte && !cfg_wr_en |=> running_crc_r == mode_init(eff_mode(mode_r)))
    else $error("running crc not reloaded after frame end");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r && !out_ready)
    else $error("input stalled with free output register");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import crc16mc_pkg::*;

  localparam int STALL_LIMIT = 2000;

  // stored crc choices for the last byte of a frame
  typedef enum int {
    STORED_EXACT,
    STORED_SWAPPED,
    STORED_REVERSED,
    STORED_RANDOM
  } stored_kind_e;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;

  bit idle_en = 1'b1;
  int modes_used;

  crc16_multimode_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // running crc predictor plus the queue of frame crcs still owed by the block
  class crc_frame_tracker;
    logic [2:0]  mode;
    logic [15:0] running;
    out_t        pending_crcs[$];
    int          errors;
    int          bytes_seen;
    int          frames_checked;
    int          frames_matched;

    function new();
      set_mode(MODE_REFL_NOXOR);
    endfunction

    // codes above modbus act as the plain reflected variant
    function logic [2:0] active_mode();
      return (mode > MODE_MODBUS) ? MODE_REFL_NOXOR : mode;
    endfunction

    function logic [15:0] seed_value();
      return (active_mode() == MODE_XMODEM) ? CRC_ZERO : CRC_ONES;
    endfunction

    function void set_mode(logic [2:0] m);
      mode    = m;
      running = seed_value();
    endfunction

    function logic [15:0] advance(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        carry;
      logic [15:0] poly;
      c = crc;
      if (active_mode() == MODE_CCITT_FALSE || active_mode() == MODE_XMODEM) begin
        c[15:8] = c[15:8] ^ b;
        for (int i = 0; i < 8; i++) begin
          carry = c[15];
          c = c << 1;
          if (carry) c = c ^ POLY_NORMAL;
        end
      end else begin
        poly = (active_mode() == MODE_MODBUS) ? POLY_REFL_MODBUS : POLY_REFL_CCITT;
        c[7:0] = c[7:0] ^ b;
        for (int i = 0; i < 8; i++) begin
          carry = c[0];
          c = c >> 1;
          if (carry) c = c ^ poly;
        end
      end
      return c;
    endfunction

    function logic [15:0] finish_crc(logic [15:0] crc);
      return (active_mode() == MODE_X25) ? ~crc : crc;
    endfunction

    // crc the frame would end with if b were its last byte
    function logic [15:0] preview(logic [7:0] b);
      return finish_crc(advance(running, b));
    endfunction

    function void fold_byte(in_t t);
      out_t        want;
      logic [15:0] rev;
      bytes_seen++;
      running = advance(running, t.data_byte);
      if (t.last_byte) begin
        want.crc_value = finish_crc(running);
        rev = {<<{want.crc_value}};
        want.crc_match = (want.crc_value == t.stored_crc) ||
                         (want.crc_value == {t.stored_crc[7:0], t.stored_crc[15:8]}) ||
                         (rev == t.stored_crc);
        pending_crcs.push_back(want);
        running = seed_value();
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_result(out_t got);
      out_t want;
      if (pending_crcs.size() == 0) begin
        report($sformatf("unexpected result crc %h match %b", got.crc_value, got.crc_match));
        return;
      end
      want = pending_crcs.pop_front();
      frames_checked++;
      if (want.crc_match) frames_matched++;
      if (got.crc_value !== want.crc_value)
        report($sformatf("frame %0d crc %h, want %h", frames_checked, got.crc_value,
                         want.crc_value));
      if (got.crc_match !== want.crc_match)
        report($sformatf("frame %0d match flag %b, want %b", frames_checked, got.crc_match,
                         want.crc_match));
    endtask
  endclass

  crc_frame_tracker board = new();

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic in_t pack_byte(logic [7:0] b, logic last, logic [15:0] stored);
    in_t t;
    t.data_byte  = b;
    t.last_byte  = last;
    t.stored_crc = stored;
    return t;
  endfunction

  function automatic logic [15:0] stored_for(logic [7:0] b, stored_kind_e kind);
    logic [15:0] fin;
    logic [15:0] rev;
    fin = board.preview(b);
    rev = {<<{fin}};
    case (kind)
      STORED_EXACT:    return fin;
      STORED_SWAPPED:  return {fin[7:0], fin[15:8]};
      STORED_REVERSED: return rev;
      default:         return 16'($urandom);
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input in_t item);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.fold_byte(item);
    @(negedge clk);
  endtask

  // sender holds off until every owed result is back, then idles briefly
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending_crcs.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_mode(input logic [2:0] m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.set_mode(m);
    modes_used++;
  endtask

  task automatic run_phase(input logic [2:0] m, input int quota);
    int          sent;
    int          len;
    int          pick;
    logic [7:0]  b;
    stored_kind_e kind;
    drain_results();
    write_mode(m);
    sent = 0;
    while (sent < quota) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      for (int i = 0; i < len - 1; i++) begin
        send_byte(pack_byte(8'($urandom), 1'b0, 16'($urandom)));
      end
      b = 8'($urandom);
      pick = $urandom_range(0, 7);
      kind = (pick < 2) ? STORED_EXACT : (pick == 2) ? STORED_SWAPPED :
             (pick == 3) ? STORED_REVERSED : STORED_RANDOM;
      send_byte(pack_byte(b, 1'b1, stored_for(b, kind)));
      sent += len;
    end
    // sometimes leave a frame half done so the mode write has to drop it
    if ($urandom_range(0, 1) == 1) begin
      len = $urandom_range(1, 3);
      repeat (len) send_byte(pack_byte(8'($urandom), 1'b0, 16'($urandom)));
    end
  endtask

  // receiver: open stretches, with random stall bursts in between while idle_en is set
  initial begin
    int run;
    out_ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      run = $urandom_range(1, 40);
      repeat (run) @(negedge clk);
      if (idle_en) begin
        out_ready <= 1'b0;
        run = $urandom_range(1, 19);
        repeat (run) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.compare_result(out_data);
  end

  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall = 0;
      else stall++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("tb failed");
    $finish;
  end

  initial begin
    logic [7:0]  check_str[9];
    logic [2:0]  phase_modes[12];
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = MODE_REFL_NOXOR;
    check_str   = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    phase_modes = '{MODE_X25, MODE_CCITT_FALSE, MODE_XMODEM, MODE_MODBUS, 3'd5,
                    MODE_REFL_NOXOR, MODE_XMODEM, 3'd6, MODE_CCITT_FALSE, 3'd7,
                    MODE_X25, MODE_MODBUS};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset mode: field extremes and each way the stored crc can match
    send_byte(pack_byte(8'h00, 1'b1, 16'h0000));
    send_byte(pack_byte(8'hFF, 1'b1, 16'hFFFF));
    for (int i = 0; i < 8; i++) send_byte(pack_byte(check_str[i], 1'b0, 16'hFFFF));
    send_byte(pack_byte(check_str[8], 1'b1, stored_for(check_str[8], STORED_EXACT)));
    send_byte(pack_byte(8'h55, 1'b1, stored_for(8'h55, STORED_SWAPPED)));
    send_byte(pack_byte(8'hAA, 1'b1, stored_for(8'hAA, STORED_REVERSED)));
    send_byte(pack_byte(8'h80, 1'b0, 16'hA5A5));
    send_byte(pack_byte(8'h01, 1'b1, 16'h5A5A));
    // open frame dropped by the next mode write
    send_byte(pack_byte(8'h7E, 1'b0, 16'h0000));
    send_byte(pack_byte(8'hC3, 1'b0, 16'hFFFF));

    for (int p = 0; p < 12; p++) begin
      if (p == 11) idle_en = 1'b0;
      run_phase(phase_modes[p], 60);
    end

    drain_results();
    repeat (5) @(negedge clk);
    if (board.pending_crcs.size() != 0)
      board.report($sformatf("%0d frame results never arrived", board.pending_crcs.size()));
    $display("run covered %0d bytes and %0d frame crcs (%0d flagged matching)",
             board.bytes_seen, board.frames_checked, board.frames_matched);
    $display("across %0d mode writes, undefined mode codes and dropped frames included",
             modes_used);
    if (board.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/crc16mc_pkg.sv
rtl/crc16_multimode_check.sv
test/tb.sv
